// ===== hw/rtl/pts_pkg.sv =====
// ----------------------------------------------------------------------------
// pts_pkg
// shared types and constants of the perspective texture span walker
// ----------------------------------------------------------------------------
package pts_pkg;

  localparam int Z_W      = 31;
  localparam int DIV_N_W  = 56;
  localparam int DIV_D_W  = 33;
  localparam int CNT_W    = 6;
  localparam logic [Z_W-1:0] SAT31 = {Z_W{1'b1}};
  localparam logic [3:0] LG_MAX = 4'd10;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_STEP  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [1:0] REG_ZPREC = 2'd0;
  localparam logic [1:0] REG_TEXW  = 2'd1;
  localparam logic [1:0] REG_TEXH  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_ZDIV,
    ST_UDIV,
    ST_VDIV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] num;
    logic [DIV_D_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_N_W-1:0] quot;
  } div_rsp_t;

endpackage

// ===== hw/rtl/pts_zbuf.sv =====
// ----------------------------------------------------------------------------
// pts_zbuf
// z-buffer memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module pts_zbuf #(
  parameter int DEPTH  = 76800,
  parameter int ADDR_W = 17
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [ADDR_W-1:0]     waddr,
  input  logic [pts_pkg::Z_W-1:0] wdata,
  input  logic                  re,
  input  logic [ADDR_W-1:0]     raddr,
  output logic [pts_pkg::Z_W-1:0] rdata
);
  import pts_pkg::*;

  logic [Z_W-1:0] mem [DEPTH];
  logic [Z_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/pts_divider.sv =====
// ----------------------------------------------------------------------------
// pts_divider
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module pts_divider (
  input  logic                clk,
  input  logic                rst_n,
  input  pts_pkg::div_req_t   req,
  output pts_pkg::div_rsp_t   rsp
);
  import pts_pkg::*;

  logic [DIV_N_W-1:0] num_r;
  logic [DIV_D_W-1:0] den_r;
  logic [DIV_D_W:0]   rem_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               busy_r;
  logic               done_r;
  logic [DIV_D_W:0]   rem_sh;
  logic               ge;

  always_comb begin
    rem_sh = {rem_r[DIV_D_W-1:0], num_r[DIV_N_W-1]};
    ge     = rem_sh >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        num_r  <= req.num;
        den_r  <= req.den;
        rem_r  <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= ge ? (rem_sh - {1'b0, den_r}) : rem_sh;
        num_r <= {num_r[DIV_N_W-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_N_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = num_r;

endmodule

// ===== hw/rtl/perspective_texture_span_walker_core.sv =====
// ----------------------------------------------------------------------------
// perspective_texture_span_walker_core
// span load, per-pixel z test with texel coordinates, z entry clear
// ----------------------------------------------------------------------------
// a clear is taken in idle; a span load steps through the multiply and add states
// once per attribute; a pixel step runs one depth division in the bit-serial divider
// on a depth test failure and three (depth, u, v) on a pass. one item at a time
// reset: rst_n synchronous active low resets control state and configuration registers;
// z-buffer contents are undefined until cleared, there is no clearing pass
module perspective_texture_span_walker_core #(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 240
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // row_y, start_x_fix, end_x_fix, inv_depth_start, inv_w_start,
  // u_over_w_start, v_over_w_start, inv_depth_step, inv_w_step,
  // u_over_w_step, v_over_w_step, zero pad
  input  logic [335:0] in_tdata,
  // cmd
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // pixel_x, pixel_y, depth_value, texel_u, texel_v, zero pad
  output logic [71:0]  out_tdata,
  // write_enable
  output logic [0:0]   out_tuser,
  output logic         out_tlast,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [30:0]  cfg_wdata
);
  import pts_pkg::*;

  localparam int DEPTH  = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int COL_W  = $clog2(SCREEN_WIDTH);
  localparam int ROW_W  = $clog2(SCREEN_HEIGHT);
  localparam logic signed [17:0] W_LAST = 18'(SCREEN_WIDTH - 1);
  localparam logic [32:0] SCR_W = 33'(SCREEN_WIDTH);
  localparam logic [10:0] SCR_H = 11'(SCREEN_HEIGHT);

  state_t state_r, state_nxt;

  logic [Z_W-1:0] zprec_r;
  logic [3:0]     texw_r, texh_r;

  logic             span_active_r;
  logic [COL_W-1:0] cur_x_r, last_x_r;
  logic [ROW_W-1:0] span_row_r;
  logic [31:0]      acc_r  [4];
  logic [31:0]      step_r [4];
  logic [31:0]      dx_r;
  logic [31:0]      prod_r;
  logic [1:0]       mul_idx_r;
  logic             load_ok_r;

  logic [Z_W-1:0] z_r;
  logic           pass_r;
  logic [9:0]     tu_r, tv_r;

  logic           out_valid_r;
  logic [71:0]    out_data_r;
  logic           out_we_r, out_last_r;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic           mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr, pix_addr;
  logic [Z_W-1:0] mem_wdata, mem_rdata;

  // input fields
  logic [1:0]  cmd;
  logic [9:0]  row_y;
  logic [31:0] x1, x2;
  logic        accept;

  // span setup
  logic signed [32:0] x1_sum, x2_sum;
  logic signed [16:0] lo_raw;
  logic signed [17:0] hi_raw, hi_c;
  logic [16:0]        lo_c;
  logic               span_empty;
  logic [33:0]        dx_full;

  logic signed [64:0] prod_full;

  // depth and texel
  logic [Z_W-1:0] z_val;
  logic           pass_val;
  logic [3:0]     lg_u, lg_v, lg_sel;
  logic [31:0]    uv_sel;
  logic [31:0]    mag_w, mag_uv;
  logic [41:0]    an_sh;
  logic [42:0]    tex_num;
  logic           tex_neg;
  logic [9:0]     q_lo, q_sgn, tex_mask, tex_val;
  logic           inv_w_zero;

  assign cmd    = in_tuser;
  assign row_y  = in_tdata[9:0];
  assign x1     = in_tdata[41:10];
  assign x2     = in_tdata[73:42];
  assign accept = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    x1_sum  = $signed({x1[31], x1}) + 33'sd65535;
    x2_sum  = $signed({x2[31], x2}) + 33'sd65535;
    lo_raw  = x1_sum[32:16];
    hi_raw  = $signed({x2_sum[32], x2_sum[32:16]}) - 18'sd1;
    lo_c    = lo_raw[16] ? 17'd0 : lo_raw;
    hi_c    = (hi_raw > W_LAST) ? W_LAST : hi_raw;
    span_empty = ($signed({1'b0, lo_c}) > hi_c) || ({1'b0, row_y} >= SCR_H);
    dx_full = {1'b0, lo_c, 16'd0} - {{2{x1[31]}}, x1};
  end

  always_comb begin
    prod_full = $signed({1'b0, dx_r}) * $signed(step_r[mul_idx_r]);
  end

  assign pix_addr = ADDR_W'(span_row_r * SCREEN_WIDTH) + ADDR_W'(cur_x_r);

  always_comb begin
    if (acc_r[0][31] || (acc_r[0] == 32'd0) || (|div_rsp.quot[DIV_N_W-1:Z_W])) begin
      z_val = SAT31;
    end else begin
      z_val = div_rsp.quot[Z_W-1:0];
    end
    pass_val = z_val < mem_rdata;
  end

  // texel numerator and denominator, v while in u phase, else u
  always_comb begin
    lg_u   = (texw_r > LG_MAX) ? LG_MAX : texw_r;
    lg_v   = (texh_r > LG_MAX) ? LG_MAX : texh_r;
    lg_sel = (state_r == ST_UDIV) ? lg_v : lg_u;
    uv_sel = (state_r == ST_UDIV) ? acc_r[3] : acc_r[2];
    mag_w  = acc_r[1][31] ? (32'd0 - acc_r[1]) : acc_r[1];
    mag_uv = uv_sel[31] ? (32'd0 - uv_sel) : uv_sel;
    an_sh  = {10'd0, mag_uv} << lg_sel;
    tex_num = {an_sh, 1'b0} + {11'd0, mag_w};
    inv_w_zero = (acc_r[1] == 32'd0);
  end

  // texel result for the division just finished
  always_comb begin
    logic [3:0] lg_res;
    logic [31:0] uv_res;
    lg_res   = (state_r == ST_VDIV) ? lg_v : lg_u;
    uv_res   = (state_r == ST_VDIV) ? acc_r[3] : acc_r[2];
    tex_neg  = uv_res[31] != acc_r[1][31];
    q_lo     = div_rsp.quot[9:0];
    q_sgn    = tex_neg ? (10'd0 - q_lo) : q_lo;
    tex_mask = 10'((11'd1 << lg_res) - 11'd1);
    tex_val  = inv_w_zero ? 10'd0 : (q_sgn & tex_mask);
  end

  always_comb begin
    state_nxt     = state_r;
    div_req.start = 1'b0;
    div_req.num   = {1'b0, zprec_r, 24'd0};
    div_req.den   = {2'b0, acc_r[0][30:0]};
    mem_we    = 1'b0;
    mem_waddr = pix_addr;
    mem_wdata = z_val;
    mem_re    = 1'b0;
    mem_raddr = pix_addr;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (cmd)
            CMD_LOAD: begin
              if (!span_empty) begin
                state_nxt = ST_MUL;
              end
            end
            CMD_STEP: begin
              if (span_active_r) begin
                div_req.start = 1'b1;
                mem_re    = 1'b1;
                state_nxt = ST_ZDIV;
              end
            end
            CMD_CLEAR: begin
              if ((x1 < 32'(SCR_W)) && ({1'b0, row_y} < SCR_H)) begin
                mem_we    = 1'b1;
                mem_waddr = ADDR_W'(ROW_W'(row_y) * SCREEN_WIDTH) + ADDR_W'(COL_W'(x1));
                mem_wdata = zprec_r;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_MUL: begin
        state_nxt = ST_ADD;
      end
      ST_ADD: begin
        if (mul_idx_r == 2'd3) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_MUL;
        end
      end
      ST_ZDIV: begin
        if (div_rsp.done) begin
          if (pass_val) begin
            mem_we        = 1'b1;
            div_req.start = 1'b1;
            div_req.num   = {13'd0, tex_num};
            div_req.den   = {mag_w, 1'b0};
            state_nxt     = ST_UDIV;
          end else begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_UDIV: begin
        if (div_rsp.done) begin
          div_req.start = 1'b1;
          div_req.num   = {13'd0, tex_num};
          div_req.den   = {mag_w, 1'b0};
          state_nxt     = ST_VDIV;
        end
      end
      ST_VDIV: begin
        if (div_rsp.done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zprec_r <= 31'd16777216;
      texw_r  <= 4'd8;
      texh_r  <= 4'd8;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ZPREC: zprec_r <= cfg_wdata;
        REG_TEXW:  texw_r  <= cfg_wdata[3:0];
        REG_TEXH:  texh_r  <= cfg_wdata[3:0];
        default: begin
        end
      endcase
    end
  end

  // span state and datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      span_active_r <= 1'b0;
      cur_x_r       <= '0;
      last_x_r      <= '0;
      span_row_r    <= '0;
      mul_idx_r     <= '0;
      load_ok_r     <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (accept && (cmd == CMD_LOAD)) begin
            span_active_r <= 1'b0;
            load_ok_r     <= !span_empty;
            mul_idx_r     <= '0;
            cur_x_r       <= COL_W'(lo_c);
            last_x_r      <= COL_W'(hi_c);
            span_row_r    <= ROW_W'(row_y);
            dx_r          <= dx_full[31:0];
            for (int i = 0; i < 4; i++) begin
              acc_r[i]  <= in_tdata[74 + 32*i +: 32];
              step_r[i] <= in_tdata[202 + 32*i +: 32];
            end
          end
        end
        ST_MUL: begin
          prod_r <= prod_full[47:16];
        end
        ST_ADD: begin
          acc_r[mul_idx_r] <= acc_r[mul_idx_r] + prod_r;
          mul_idx_r        <= mul_idx_r + 2'd1;
          if (mul_idx_r == 2'd3) begin
            span_active_r <= load_ok_r;
          end
        end
        ST_ZDIV: begin
          if (div_rsp.done) begin
            z_r    <= z_val;
            pass_r <= pass_val;
            tu_r   <= 10'd0;
            tv_r   <= 10'd0;
          end
        end
        ST_UDIV: begin
          if (div_rsp.done) begin
            tu_r <= tex_val;
          end
        end
        ST_VDIV: begin
          if (div_rsp.done) begin
            tv_r <= tex_val;
          end
        end
        ST_EMIT: begin
          if (!out_valid_r || out_tready) begin
            for (int i = 0; i < 4; i++) begin
              acc_r[i] <= acc_r[i] + step_r[i];
            end
            if (cur_x_r >= last_x_r) begin
              span_active_r <= 1'b0;
            end else begin
              cur_x_r <= cur_x_r + 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      if ((state_r == ST_EMIT) && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
        out_data_r  <= {1'b0, tv_r, tu_r, z_r, 10'(span_row_r), 10'(cur_x_r)};
        out_we_r    <= pass_r;
        out_last_r  <= (cur_x_r >= last_x_r);
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_we_r;
  assign out_tlast  = out_last_r;

  pts_zbuf #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_zbuf (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  pts_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the perspective texture span walker core: span
// loads, pixel steps and z clears go in over the input stream, every pixel
// result is predicted from a local copy of span state and z-buffer and
// compared field by field; both streams idle at random, registers change
// between phases
// ----------------------------------------------------------------------------
module tb_top;
  import pts_pkg::*;

  localparam int SW = 320;
  localparam int SH = 240;
  localparam int CLK_HALF = 4;
  localparam int SETTLE = 200;

  typedef struct packed {
    logic [31:0] vw_step;
    logic [31:0] uw_step;
    logic [31:0] iw_step;
    logic [31:0] id_step;
    logic [31:0] vw;
    logic [31:0] uw;
    logic [31:0] iw;
    logic [31:0] id;
    logic [31:0] x2;
    logic [31:0] x1;
    logic [9:0]  row;
  } span_word_t;

  typedef struct packed {
    logic [9:0]     tv;
    logic [9:0]     tu;
    logic [Z_W-1:0] depth;
    logic [9:0]     py;
    logic [9:0]     px;
  } pixel_word_t;

  typedef struct {
    pixel_word_t w;
    logic        we;
    logic        done;
  } pixel_res_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [335:0] in_tdata = '0;
  logic [1:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [71:0]  out_tdata;
  logic [0:0]   out_tuser;
  logic         out_tlast;
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_index = '0;
  logic [30:0]  cfg_wdata = '0;

  perspective_texture_span_walker_core #(
    .SCREEN_WIDTH (SW),
    .SCREEN_HEIGHT(SH)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #(CLK_HALF) clk = ~clk;

  // local copy of block state
  logic [31:0]    zbuf [0:SW*SH-1];
  logic [Z_W-1:0] zprec;
  logic [3:0]     texw_lg;
  logic [3:0]     texh_lg;
  logic [10:0]    walk_x;
  logic [10:0]    walk_last;
  logic [9:0]     walk_row;
  logic           walk_on;
  logic [31:0]    attr_acc [4];
  logic [31:0]    attr_stp [4];

  pixel_res_t pixel_q [$];
  int  err_cnt = 0;
  int  n_sent = 0;
  int  n_pixels = 0;
  int  n_passes = 0;
  bit  idle_on = 1'b1;
  int  out_stall = 0;

  function automatic logic [9:0] texel_coord(logic [31:0] ow, logic [31:0] iw, logic [3:0] lg);
    longint den;
    longint num;
    longint unsigned an;
    longint unsigned ad;
    longint unsigned q;
    int l;
    bit neg;
    l = (lg > LG_MAX) ? 10 : int'(lg);
    den = longint'($signed(iw));
    if (den == 0) return '0;
    num = longint'($signed(ow)) * (longint'(1) << l);
    neg = (num < 0) != (den < 0);
    an = (num < 0) ? longint'(-num) : num;
    ad = (den < 0) ? longint'(-den) : den;
    q = (2 * an + ad) / (2 * ad);
    if (neg) q = -q;
    return 10'(q & ((64'd1 << l) - 1));
  endfunction

  task automatic model_span_walker(input logic [1:0] cmd, input span_word_t it);
    longint x1;
    longint x2;
    longint lo;
    longint hi;
    longint dx;
    longint st [4];
    longint sp [4];
    longint inv;
    longint unsigned z;
    longint unsigned col;
    int idx;
    pixel_res_t r;
    x1 = longint'($signed(it.x1));
    x2 = longint'($signed(it.x2));
    st = '{longint'($signed(it.id)), longint'($signed(it.iw)),
           longint'($signed(it.uw)), longint'($signed(it.vw))};
    sp = '{longint'($signed(it.id_step)), longint'($signed(it.iw_step)),
           longint'($signed(it.uw_step)), longint'($signed(it.vw_step))};
    case (cmd)
      CMD_LOAD: begin
        lo = (x1 + 65535) >>> 16;
        hi = ((x2 + 65535) >>> 16) - 1;
        walk_on = 1'b0;
        if (lo < 0) lo = 0;
        if (hi > SW - 1) hi = SW - 1;
        if (lo <= hi && it.row < SH) begin
          dx = lo * 65536 - x1;
          for (int i = 0; i < 4; i++) begin
            attr_acc[i] = 32'(st[i] + ((dx * sp[i]) >>> 16));
            attr_stp[i] = 32'(sp[i]);
          end
          walk_x = 11'(lo);
          walk_last = 11'(hi);
          walk_row = it.row;
          walk_on = 1'b1;
        end
      end
      CMD_CLEAR: begin
        col = longint'(it.x1);
        if (col < SW && it.row < SH) zbuf[int'(it.row) * SW + int'(col)] = 32'(zprec);
      end
      CMD_STEP: begin
        if (walk_on) begin
          inv = longint'($signed(attr_acc[0]));
          idx = (int'(walk_row) % SH) * SW + (int'(walk_x) % SW);
          if (inv <= 0) begin
            z = longint'(SAT31);
          end else begin
            z = (longint'(zprec) << 24) / inv;
            if (z > longint'(SAT31)) z = longint'(SAT31);
          end
          r.we = z < longint'(zbuf[idx]);
          r.done = walk_x >= walk_last;
          r.w.px = walk_x[9:0];
          r.w.py = walk_row;
          r.w.depth = Z_W'(z);
          r.w.tu = '0;
          r.w.tv = '0;
          if (r.we) begin
            zbuf[idx] = 32'(z);
            r.w.tu = texel_coord(attr_acc[2], attr_acc[1], texw_lg);
            r.w.tv = texel_coord(attr_acc[3], attr_acc[1], texh_lg);
          end
          pixel_q.push_back(r);
          for (int i = 0; i < 4; i++) attr_acc[i] = attr_acc[i] + attr_stp[i];
          if (r.done) walk_on = 1'b0;
          else walk_x = walk_x + 11'd1;
        end
      end
      default: ;
    endcase
  endtask

  // one input transfer; tvalid stays high on return unless a random idle gap was inserted
  task automatic send_item(input logic [1:0] cmd, input span_word_t it);
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {6'b0, it};
    do @(posedge clk); while (!in_tready);
    model_span_walker(cmd, it);
    n_sent++;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    int guard;
    guard = 0;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pixel_q.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    if (pixel_q.size() != 0) begin
      $display("status: fail");
      $finish;
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [30:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_ZPREC: zprec = val;
      REG_TEXW:  texw_lg = val[3:0];
      REG_TEXH:  texh_lg = val[3:0];
      default: ;
    endcase
  endtask

  function automatic span_word_t rand_word();
    span_word_t w;
    w = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
         $urandom, $urandom, $urandom, $urandom, 10'($urandom)};
    return w;
  endfunction

  function automatic logic [9:0] prep_row();
    int s;
    s = $urandom_range(0, 2);
    return (s == 2) ? 10'(SH - 1) : 10'(s);
  endfunction

  function automatic logic [31:0] small_signed(int span);
    return 32'($urandom_range(0, 2 * span) - span);
  endfunction

  task automatic clear_entry(input logic [9:0] row, input logic [31:0] col);
    span_word_t w;
    w = rand_word();
    w.row = row;
    w.x1 = col;
    send_item(CMD_CLEAR, w);
  endtask

  // z entries of rows 0, 1 and the last row are made valid before use
  task automatic test_zbuf_prepare();
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < SW; c++) clear_entry((r == 2) ? 10'(SH - 1) : 10'(r), 32'(c));
    clear_entry(10'd0, 32'(SW));
    clear_entry(10'(SH), 32'd0);
    clear_entry(10'd1023, 32'hFFFF_FFFF);
  endtask

  task automatic test_directed();
    span_word_t w;
    w = rand_word();
    send_item(CMD_STEP, w);
    send_item(2'd3, w);
    w = rand_word();
    w.row = 10'(SH);
    w.x1 = 32'h0001_0000;
    w.x2 = 32'h0008_0000;
    send_item(CMD_LOAD, w);
    send_item(CMD_STEP, w);
    w = rand_word();
    w.row = 10'd1023;
    send_item(CMD_LOAD, w);
    w.row = 10'd3;
    w.x1 = 32'h0005_8000;
    w.x2 = 32'h0005_C000;
    send_item(CMD_LOAD, w);
    send_item(CMD_STEP, w);
    // clipped left, depth negative, one over w zero
    w = rand_word();
    w.row = 10'd0;
    w.x1 = 32'h8000_0000;
    w.x2 = 32'h0002_0001;
    w.id = 32'h0000_0000;
    w.id_step = 32'hFFFF_FFFF;
    w.iw = '0;
    w.iw_step = '0;
    w.id = -(32'(longint'(w.id_step) * 0));
    send_item(CMD_LOAD, w);
    repeat (3) send_item(CMD_STEP, w);
    // clipped right
    w = rand_word();
    w.row = 10'(SH - 1);
    w.x1 = 32'(317 * 65536 + 32768);
    w.x2 = 32'h7FFF_FFFF;
    w.id = 32'h0400_0000;
    w.id_step = 32'h0000_1000;
    send_item(CMD_LOAD, w);
    repeat (3) send_item(CMD_STEP, w);
    // full-scale attributes on one pixel
    w.row = 10'd1;
    w.x1 = 32'h0013_0000;
    w.x2 = 32'h0014_0000;
    w.id = 32'h7FFF_FFFF;
    w.iw = 32'h8000_0000;
    w.uw = 32'h7FFF_FFFF;
    w.vw = 32'h8000_0000;
    w.id_step = 32'h8000_0000;
    w.iw_step = 32'h7FFF_FFFF;
    w.uw_step = 32'h8000_0000;
    w.vw_step = 32'h7FFF_FFFF;
    send_item(CMD_LOAD, w);
    send_item(CMD_STEP, w);
    w.iw = 32'h0100_0000;
    w.uw = 32'h0080_0000;
    w.vw = 32'hFF80_0000;
    send_item(CMD_LOAD, w);
    send_item(CMD_STEP, w);
  endtask

  task automatic rand_span();
    span_word_t w;
    int col0;
    int len;
    int nst;
    w.row = prep_row();
    col0 = $urandom_range(0, 340) - 10;
    len = $urandom_range(0, 12);
    w.x1 = 32'(col0 * 65536 - int'($urandom_range(0, 65535)));
    w.x2 = 32'(longint'($signed(w.x1)) + len * 65536 + $urandom_range(0, 65535));
    w.id = 32'($urandom_range(24'hFF_0000, 32'h0400_0000));
    w.id_step = small_signed(1 << 20);
    w.iw = 32'($urandom_range(1 << 22, 1 << 26));
    w.iw_step = small_signed(1 << 18);
    w.uw = small_signed(1 << 28);
    w.vw = small_signed(1 << 28);
    w.uw_step = small_signed(1 << 22);
    w.vw_step = small_signed(1 << 22);
    if ($urandom_range(0, 15) == 0) begin
      w.iw = '0;
      w.iw_step = '0;
    end
    if ($urandom_range(0, 15) == 0) w.id = small_signed(1 << 10);
    send_item(CMD_LOAD, w);
    nst = ($urandom_range(0, 5) == 0) ? $urandom_range(0, len + 2) : len + 1;
    repeat (nst) send_item(CMD_STEP, rand_word());
  endtask

  task automatic test_random(input int target);
    int r;
    span_word_t w;
    while (n_sent < target) begin
      r = $urandom_range(0, 19);
      if (r < 15) begin
        rand_span();
      end else if (r < 17) begin
        clear_entry(prep_row(), 32'($urandom_range(0, SW - 1)));
      end else if (r == 17) begin
        send_item(2'd3, rand_word());
      end else if (r == 18) begin
        send_item(CMD_LOAD, rand_word());
      end else begin
        w = rand_word();
        if ($urandom_range(0, 1) == 0) w.row = 10'($urandom_range(SH, 1023));
        send_item(CMD_CLEAR, w);
      end
    end
  endtask

  always @(posedge clk) begin
    if (out_stall > 0) begin
      out_tready <= 1'b0;
      out_stall <= out_stall - 1;
    end else if (idle_on && rst_n && $urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      out_stall <= $urandom_range(0, 4);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    pixel_res_t e;
    pixel_word_t a;
    if (rst_n && out_tvalid && out_tready) begin
      a = out_tdata[70:0];
      if (pixel_q.size() == 0) begin
        $error("pixel result with none pending");
        err_cnt++;
      end else begin
        e = pixel_q.pop_front();
        n_pixels++;
        if (e.we) n_passes++;
        if (a.px !== e.w.px) begin
          $error("pixel_x exp %0d got %0d", e.w.px, a.px); err_cnt++;
        end
        if (a.py !== e.w.py) begin
          $error("pixel_y exp %0d got %0d", e.w.py, a.py); err_cnt++;
        end
        if (a.depth !== e.w.depth) begin
          $error("depth_value exp %0d got %0d", e.w.depth, a.depth); err_cnt++;
        end
        if (a.tu !== e.w.tu) begin
          $error("texel_u exp %0d got %0d", e.w.tu, a.tu); err_cnt++;
        end
        if (a.tv !== e.w.tv) begin
          $error("texel_v exp %0d got %0d", e.w.tv, a.tv); err_cnt++;
        end
        if (out_tuser[0] !== e.we) begin
          $error("write_enable exp %0d got %0d", e.we, out_tuser[0]); err_cnt++;
        end
        if (out_tlast !== e.done) begin
          $error("span_done exp %0d got %0d", e.done, out_tlast); err_cnt++;
        end
      end
    end
  end

  initial begin
    #(20_000_000);
    $display("status: fail");
    $finish;
  end

  initial begin
    zprec = 31'd16777216;
    texw_lg = 4'd8;
    texh_lg = 4'd8;
    walk_x = '0;
    walk_last = '0;
    walk_row = '0;
    walk_on = 1'b0;
    for (int i = 0; i < 4; i++) begin
      attr_acc[i] = '0;
      attr_stp[i] = '0;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_zbuf_prepare();
    test_directed();
    test_random(n_sent + 240);
    wait_idle();
    write_reg(REG_ZPREC, 31'd1);
    write_reg(REG_TEXW, 31'd0);
    write_reg(REG_TEXH, 31'd0);
    test_random(n_sent + 240);
    wait_idle();
    write_reg(REG_ZPREC, 31'h7FFF_FFFF);
    write_reg(REG_TEXW, 31'd10);
    write_reg(REG_TEXH, 31'd15);
    test_random(n_sent + 240);
    wait_idle();
    write_reg(REG_ZPREC, 31'($urandom_range(1 << 20, 1 << 26)));
    write_reg(REG_TEXW, 31'($urandom_range(0, 15)));
    write_reg(REG_TEXH, 31'($urandom_range(0, 15)));
    idle_on = 1'b0;
    test_random(n_sent + 240);
    wait_idle();
    $display("sent %0d input transfers over four register settings", n_sent);
    $display("checked %0d pixel results, %0d with a depth pass", n_pixels, n_passes);
    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
